@@ hdl/uart_reply_message_framer_assert.svh @@
// ----------------------------------------------------------------------------
// uart reply framer assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef UART_REPLY_MESSAGE_FRAMER_ASSERT_SVH
`define UART_REPLY_MESSAGE_FRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
// checked property, disabled while in reset
`define URMF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked property, also active during reset
`define URMF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define URMF_ASSERT(label, clk, rst_n, prop, msg)
`define URMF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hdl/urmf_pkg.sv @@
// ----------------------------------------------------------------------------
// uart reply framer package
// shared sizes, codes, word types and constants
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urmf_pkg;

    localparam int NAME_LEN    = 16;
    localparam int NUM_FILES   = 3;
    localparam int STORE_DEPTH = NUM_FILES * NAME_LEN;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int POS_W       = $clog2(NAME_LEN);
    localparam int IDX_W       = ($clog2(NAME_LEN + 2) > 3) ? $clog2(NAME_LEN + 2) : 3;

    localparam int VAL_W   = 14;
    localparam int STICK_W = 10;
    localparam int CFG_W   = 14;
    localparam int FILE_W  = 2;
    localparam int NIDX_W  = 4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_READY = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    localparam logic [1:0] CFG_STEPS   = 2'd0;
    localparam logic [1:0] CFG_STICK_X = 2'd1;
    localparam logic [1:0] CFG_STICK_Y = 2'd2;

    localparam logic [2:0] KIND_PAINT = 3'd0;
    localparam logic [2:0] KIND_ACK1  = 3'd1;
    localparam logic [2:0] KIND_STEPS = 3'd2;
    localparam logic [2:0] KIND_STICK = 3'd3;
    localparam logic [2:0] KIND_NAME  = 3'd4;
    localparam logic [2:0] KIND_ACK5  = 3'd5;
    localparam logic [2:0] KIND_ACK6  = 3'd6;
    localparam logic [2:0] KIND_POS   = 3'd7;

    localparam logic [7:0] BYTE_PAINT_HDR = 8'h07;
    localparam logic [7:0] BYTE_ACK1      = 8'h01;
    localparam logic [7:0] BYTE_ACK5      = 8'h02;
    localparam logic [7:0] BYTE_ACK6      = 8'h06;
    localparam logic [7:0] FILE_BIAS      = 8'd3;
    localparam logic [7:0] CODE_BIAS      = 8'd150;
    // code of the digits of zero
    localparam logic [7:0] CODE_ZERO      = CODE_BIAS;
    localparam int         DIGIT_BASE     = 100;
    // floor(2^16 / 100), never overestimates the quotient
    localparam int         RECIP_100      = 655;
    localparam int         RECIP_SHIFT    = 16;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [2:0]        message_kind;
        logic [7:0]        paint_byte_a;
        logic [7:0]        paint_byte_b;
        logic [7:0]        paint_byte_c;
        logic [7:0]        paint_byte_d;
        logic [VAL_W-1:0]  position;
        logic [FILE_W-1:0] file_select;
        logic [NIDX_W-1:0] name_index;
        logic [7:0]        name_char;
    } item_t;

    typedef struct packed {
        logic       has;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       msg_done;
    } result_t;

endpackage

@@ hdl/urmf_digits.sv @@
// ----------------------------------------------------------------------------
// urmf digit coder
// splits a value into hundreds and units, each biased by 150
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urmf_digits
(
    input  logic [urmf_pkg::VAL_W-1:0] value,
    output logic [7:0]                 hundreds_code,
    output logic [7:0]                 units_code
);
    import urmf_pkg::*;

    localparam int PROD_W = VAL_W + 10;

    logic [PROD_W-1:0] prod;
    logic [7:0]        q_est;
    logic [VAL_W-1:0]  back;
    logic [VAL_W-1:0]  rem_est;
    logic [7:0]        q;
    logic [VAL_W-1:0]  rem;

    always_comb
    begin
        // reciprocal estimate is at most one short
        prod    = PROD_W'(value) * PROD_W'(RECIP_100);
        q_est   = prod[RECIP_SHIFT +: 8];
        back    = VAL_W'(q_est) * VAL_W'(DIGIT_BASE);
        rem_est = value - back;
        if (rem_est >= VAL_W'(DIGIT_BASE))
        begin
            q   = q_est + 8'd1;
            rem = rem_est - VAL_W'(DIGIT_BASE);
        end
        else
        begin
            q   = q_est;
            rem = rem_est;
        end
        hundreds_code = q + CODE_BIAS;
        units_code    = rem[7:0] + CODE_BIAS;
    end

endmodule

@@ hdl/urmf_name_store.sv @@
// ----------------------------------------------------------------------------
// urmf name store
// file name characters, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urmf_name_store
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [urmf_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic                        re,
    input  logic [urmf_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                  rdata
);
    import urmf_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // same-cycle write to the read address is forwarded
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/urmf_core.sv @@
// ----------------------------------------------------------------------------
// urmf framing core
// message state, byte selection and configuration registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urmf_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       process,
    input  urmf_pkg::item_t            item,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [urmf_pkg::CFG_W-1:0] cfg_data,
    output urmf_pkg::result_t          res
);
    import urmf_pkg::*;

    logic [2:0]        active_kind_reg, active_kind_next;
    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  byte_index_reg, byte_index_next;
    logic              name_ended_reg, name_ended_next;
    logic [7:0]        paint_reg [4];
    logic [7:0]        paint_next [4];
    logic [7:0]        pos_h_reg, pos_h_next;
    logic [7:0]        pos_u_reg, pos_u_next;
    logic [FILE_W-1:0] file_reg, file_next;
    logic              rd_zero_reg;

    logic [7:0] steps_h_reg, steps_u_reg;
    logic [7:0] x_h_reg, x_u_reg;
    logic [7:0] y_h_reg, y_u_reg;

    logic [VAL_W-1:0] cfg_value;
    logic [7:0]       cfg_h, cfg_u;
    logic [7:0]       start_h, start_u;

    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic              st_re;
    logic [ADDR_W-1:0] st_raddr;
    logic [POS_W-1:0]  rd_pos;
    logic [7:0]        st_rdata;
    logic [7:0]        name_byte;

    logic [7:0]       sel_byte;
    logic             sel_done;
    logic             sel_ended;
    logic [IDX_W-1:0] sel_last;
    logic [IDX_W-1:0] idx_m1;

    // digit codes of a configuration write and of the started position
    assign cfg_value = (cfg_index == CFG_STEPS) ? cfg_data : VAL_W'(cfg_data[STICK_W-1:0]);

    urmf_digits u_cfg_digits
    (
        .value         (cfg_value),
        .hundreds_code (cfg_h),
        .units_code    (cfg_u)
    );

    urmf_digits u_pos_digits
    (
        .value         (item.position),
        .hundreds_code (start_h),
        .units_code    (start_u)
    );

    assign name_byte = rd_zero_reg ? 8'd0 : st_rdata;
    assign idx_m1    = byte_index_reg - IDX_W'(1);

    // byte of the running message at the current index
    always_comb
    begin
        sel_byte  = 8'd0;
        sel_done  = 1'b0;
        sel_ended = 1'b0;
        sel_last  = IDX_W'(1);
        case (active_kind_reg)
            KIND_PAINT:
            begin
                sel_last = IDX_W'(5);
                if (byte_index_reg >= IDX_W'(5))
                begin
                    sel_done = 1'b1;
                end
                else if (byte_index_reg == '0)
                begin
                    sel_byte = BYTE_PAINT_HDR;
                end
                else
                begin
                    sel_byte = paint_reg[idx_m1[1:0]];
                end
            end
            KIND_ACK1, KIND_ACK5, KIND_ACK6:
            begin
                sel_last = IDX_W'(1);
                if (byte_index_reg >= IDX_W'(1))
                begin
                    sel_done = 1'b1;
                end
                else if (active_kind_reg == KIND_ACK1)
                begin
                    sel_byte = BYTE_ACK1;
                end
                else if (active_kind_reg == KIND_ACK5)
                begin
                    sel_byte = BYTE_ACK5;
                end
                else
                begin
                    sel_byte = BYTE_ACK6;
                end
            end
            KIND_STEPS, KIND_POS:
            begin
                sel_last = IDX_W'(2);
                if (byte_index_reg >= IDX_W'(2))
                begin
                    sel_done = 1'b1;
                end
                else if (active_kind_reg == KIND_STEPS)
                begin
                    sel_byte = (byte_index_reg == '0) ? steps_h_reg : steps_u_reg;
                end
                else
                begin
                    sel_byte = (byte_index_reg == '0) ? pos_h_reg : pos_u_reg;
                end
            end
            KIND_STICK:
            begin
                sel_last = IDX_W'(4);
                if (byte_index_reg >= IDX_W'(4))
                begin
                    sel_done = 1'b1;
                end
                else if (byte_index_reg < IDX_W'(2))
                begin
                    sel_byte = byte_index_reg[0] ? x_u_reg : x_h_reg;
                end
                else
                begin
                    sel_byte = byte_index_reg[0] ? y_u_reg : y_h_reg;
                end
            end
            KIND_NAME:
            begin
                sel_last = IDX_W'(NAME_LEN + 1);
                if (byte_index_reg == '0)
                begin
                    sel_byte = 8'(file_reg) + FILE_BIAS;
                end
                else if (name_ended_reg || (byte_index_reg > IDX_W'(NAME_LEN)))
                begin
                    sel_done = 1'b1;
                end
                else
                begin
                    sel_byte  = name_byte;
                    sel_ended = (name_byte == 8'd0);
                end
            end
            default:
            begin
                sel_done = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        active_kind_next = active_kind_reg;
        busy_next        = busy_reg;
        byte_index_next  = byte_index_reg;
        name_ended_next  = name_ended_reg;
        paint_next       = paint_reg;
        pos_h_next       = pos_h_reg;
        pos_u_next       = pos_u_reg;
        file_next        = file_reg;
        st_we            = 1'b0;
        st_waddr         = ADDR_W'(item.file_select) * ADDR_W'(NAME_LEN)
                         + ADDR_W'(item.name_index);
        res              = '0;
        if (process)
        begin
            case (op_t'(item.opcode))
                OP_START:
                begin
                    active_kind_next = item.message_kind;
                    paint_next[0]    = item.paint_byte_a;
                    paint_next[1]    = item.paint_byte_b;
                    paint_next[2]    = item.paint_byte_c;
                    paint_next[3]    = item.paint_byte_d;
                    pos_h_next       = start_h;
                    pos_u_next       = start_u;
                    file_next        = item.file_select;
                    byte_index_next  = '0;
                    name_ended_next  = 1'b0;
                    busy_next        = 1'b1;
                end
                OP_WRITE:
                begin
                    st_we = (32'(item.file_select) < NUM_FILES)
                         && (32'(item.name_index) < NAME_LEN);
                end
                OP_READY:
                begin
                    if (busy_reg)
                    begin
                        res.has = 1'b1;
                        if (sel_done)
                        begin
                            busy_next    = 1'b0;
                            res.msg_done = 1'b1;
                        end
                        else
                        begin
                            name_ended_next = name_ended_reg | sel_ended;
                            if ((byte_index_reg < sel_last) && !name_ended_next)
                            begin
                                byte_index_next = byte_index_reg + IDX_W'(1);
                            end
                            res.tx_byte  = sel_byte;
                            res.tx_valid = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // prefetch the name character the next ready word will need
    assign rd_pos   = POS_W'(byte_index_next - IDX_W'(1));
    assign st_re    = (32'(file_next) < NUM_FILES);
    assign st_raddr = ADDR_W'(file_next) * ADDR_W'(NAME_LEN) + ADDR_W'(rd_pos);

    urmf_name_store u_name_store
    (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (item.name_char),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_kind_reg <= KIND_PAINT;
            busy_reg        <= 1'b0;
            byte_index_reg  <= '0;
            name_ended_reg  <= 1'b0;
            pos_h_reg       <= CODE_ZERO;
            pos_u_reg       <= CODE_ZERO;
            file_reg        <= '0;
            rd_zero_reg     <= 1'b1;
        end
        else
        begin
            active_kind_reg <= active_kind_next;
            busy_reg        <= busy_next;
            byte_index_reg  <= byte_index_next;
            name_ended_reg  <= name_ended_next;
            pos_h_reg       <= pos_h_next;
            pos_u_reg       <= pos_u_next;
            file_reg        <= file_next;
            rd_zero_reg     <= !st_re;
        end
    end

    always_ff @(posedge clk)
    begin
        paint_reg <= paint_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_h_reg <= CODE_ZERO;
            steps_u_reg <= CODE_ZERO;
            x_h_reg     <= CODE_ZERO;
            x_u_reg     <= CODE_ZERO;
            y_h_reg     <= CODE_ZERO;
            y_u_reg     <= CODE_ZERO;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STEPS:
                begin
                    steps_h_reg <= cfg_h;
                    steps_u_reg <= cfg_u;
                end
                CFG_STICK_X:
                begin
                    x_h_reg <= cfg_h;
                    x_u_reg <= cfg_u;
                end
                CFG_STICK_Y:
                begin
                    y_h_reg <= cfg_h;
                    y_u_reg <= cfg_u;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ hdl/uart_reply_message_framer.sv @@
// ----------------------------------------------------------------------------
// uart reply message framer
// serialises reply messages one byte per transmitter-ready word
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready) carries command words: start picks a
//   message kind and latches its payload, ready asks for the next byte, write
//   stores one file name character
//   output channel (out_valid / out_ready) returns one word per ready word
//   while a message runs: a byte with tx_valid, or msg_done at the end
//   start and write words, and ready words while idle, give no output word
//   cfg_we / cfg_index / cfg_data write the calibration registers, no wait
// timing
//   a word goes from the input register to the output register in one pass,
//   so its result is registered once the output register is free; one word
//   per cycle is sustained while out_ready stays high
// reset
//   clears the message state to idle and the calibration values to zero;
//   name characters are undefined until written
// stall
//   with the output word held the input register still takes one word, then
//   in_ready drops until out_ready frees the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "uart_reply_message_framer_assert.svh"

module uart_reply_message_framer
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [2:0]                  message_kind,
    input  logic [7:0]                  paint_byte_a,
    input  logic [7:0]                  paint_byte_b,
    input  logic [7:0]                  paint_byte_c,
    input  logic [7:0]                  paint_byte_d,
    input  logic [urmf_pkg::VAL_W-1:0]  position,
    input  logic [urmf_pkg::FILE_W-1:0] file_select,
    input  logic [urmf_pkg::NIDX_W-1:0] name_index,
    input  logic [7:0]                  name_char,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  tx_byte,
    output logic                        tx_valid,
    output logic                        msg_done,

    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [urmf_pkg::CFG_W-1:0]  cfg_data
);
    import urmf_pkg::*;

    // input register
    logic    in_valid_reg, in_valid_next;
    item_t   item_reg, item_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic    tx_valid_reg, tx_valid_next;
    logic    msg_done_reg, msg_done_next;

    logic    advance;
    logic    in_take;
    result_t res;

    // a held word moves on when the output register is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    urmf_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .process   (advance),
        .item      (item_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (in_take)
        begin
            in_valid_next          = 1'b1;
            item_next.opcode       = opcode;
            item_next.message_kind = message_kind;
            item_next.paint_byte_a = paint_byte_a;
            item_next.paint_byte_b = paint_byte_b;
            item_next.paint_byte_c = paint_byte_c;
            item_next.paint_byte_d = paint_byte_d;
            item_next.position     = position;
            item_next.file_select  = file_select;
            item_next.name_index   = name_index;
            item_next.name_char    = name_char;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        tx_byte_next   = tx_byte_reg;
        tx_valid_next  = tx_valid_reg;
        msg_done_next  = msg_done_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && res.has)
        begin
            out_valid_next = 1'b1;
            tx_byte_next   = res.tx_byte;
            tx_valid_next  = res.tx_valid;
            msg_done_next  = res.msg_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        tx_byte_reg  <= tx_byte_next;
        tx_valid_reg <= tx_valid_next;
        msg_done_reg <= msg_done_next;
    end

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign tx_valid  = tx_valid_reg;
    assign msg_done  = msg_done_reg;

    // every output word is exactly one of a byte or an end marker
    `URMF_ASSERT(a_one_kind, clk, rst_n, out_valid_reg |-> (tx_valid_reg ^ msg_done_reg), "output word must be a byte or a done marker")
    // end marker carries a zero byte
    `URMF_ASSERT(a_done_zero, clk, rst_n, (out_valid_reg && msg_done_reg) |-> (tx_byte_reg == 8'd0), "done word must carry zero byte")
    // a held input word is kept until it moves on
    `URMF_ASSERT(a_hold_item, clk, rst_n, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(item_reg)), "held input word lost or changed")
    // an undelivered output word is never overwritten
    `URMF_ASSERT(a_no_overrun, clk, rst_n, (out_valid_reg && !out_ready) |-> !advance, "output word overwritten while stalled")
    // pipeline is empty coming out of reset
    `URMF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!in_valid_reg && !out_valid_reg) || rst_n, "pipeline not empty after reset")

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// uart reply message framer testbench
// drives command words with random gaps and output stalls, predicts every
// reply byte and end-of-message word, and checks them in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import urmf_pkg::*;

    // opcode with no meaning, the block must drop it
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         IDLE_PCT    = 13;
    localparam int         PHASES      = 6;
    localparam int         PHASE_WORDS = 125;
    // pipeline is two deep, spare settle time before calling it idle
    localparam int         SETTLE      = 8;
    localparam int         STALL_LIMIT = 4000;
    localparam int         REPORT_MAX  = 10;
    localparam int         POS_MAX     = (1 << VAL_W) - 1;
    localparam int         CFG_MAX     = (1 << CFG_W) - 1;
    localparam int         STICK_MAX   = (1 << STICK_W) - 1;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [7:0]          tx_byte;
    logic                tx_valid;
    logic                msg_done;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_index = CFG_STEPS;
    logic [CFG_W-1:0]    cfg_data  = '0;

    // word currently presented on the input channel
    item_t               cur_word  = '0;
    logic                in_taken  = 1'b0;
    // no idling on either side while set
    logic                calm      = 1'b0;

    item_t               cmd_q[$];
    result_t             reply_q[$];
    int                  queued_cnt   = 0;
    int                  mismatch_cnt = 0;
    int                  stall_cnt    = 0;

    // shadow of the framer state
    logic [2:0]          kind_r  = KIND_PAINT;
    logic                busy_r  = 1'b0;
    logic [IDX_W-1:0]    idx_r   = '0;
    logic                ended_r = 1'b0;
    logic [7:0]          paint_r [4];
    logic [VAL_W-1:0]    pos_r   = '0;
    logic [FILE_W-1:0]   file_r  = '0;
    logic [7:0]          names_r [STORE_DEPTH];
    logic [CFG_W-1:0]    steps_cfg   = '0;
    logic [STICK_W-1:0]  stick_x_cfg = '0;
    logic [STICK_W-1:0]  stick_y_cfg = '0;

    uart_reply_message_framer i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (cur_word.opcode),
        .message_kind (cur_word.message_kind),
        .paint_byte_a (cur_word.paint_byte_a),
        .paint_byte_b (cur_word.paint_byte_b),
        .paint_byte_c (cur_word.paint_byte_c),
        .paint_byte_d (cur_word.paint_byte_d),
        .position     (cur_word.position),
        .file_select  (cur_word.file_select),
        .name_index   (cur_word.name_index),
        .name_char    (cur_word.name_char),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .tx_byte      (tx_byte),
        .tx_valid     (tx_valid),
        .msg_done     (msg_done),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // reply prediction
    // ------------------------------------------------------------------

    // value digits as sent: hundreds or units, biased, wrapping at a byte
    function automatic logic [7:0] digit_code(int v, bit units);
        int d;
        d = units ? (v % DIGIT_BASE) : (v / DIGIT_BASE);
        return 8'(d + CODE_BIAS);
    endfunction

    // advances the shadow state by one command word, returns the reply if any
    function automatic result_t frame_reply(item_t w);
        result_t    res;
        logic [7:0] b;
        logic       fin;
        int         idx;
        int         last;
        int         v;
        res  = '0;
        b    = '0;
        fin  = 1'b0;
        last = 0;
        if (w.opcode == OP_START)
        begin
            // start latches the payload and restarts any running message
            kind_r     = w.message_kind;
            paint_r[0] = w.paint_byte_a;
            paint_r[1] = w.paint_byte_b;
            paint_r[2] = w.paint_byte_c;
            paint_r[3] = w.paint_byte_d;
            pos_r      = w.position;
            file_r     = w.file_select;
            idx_r      = '0;
            ended_r    = 1'b0;
            busy_r     = 1'b1;
            return res;
        end
        if (w.opcode == OP_WRITE)
        begin
            // writes outside the store are dropped
            if (w.file_select < NUM_FILES && w.name_index < NAME_LEN)
                names_r[w.file_select * NAME_LEN + w.name_index] = w.name_char;
            return res;
        end
        // unused opcode, or ready while idle
        if (w.opcode != OP_READY || !busy_r)
            return res;

        idx = idx_r;
        case (kind_r)
            KIND_PAINT:
            begin
                if (idx >= 5)
                    fin = 1'b1;
                else if (idx == 0)
                    b = BYTE_PAINT_HDR;
                else
                    b = paint_r[(idx - 1) & 3];
                last = 5;
            end
            KIND_ACK1, KIND_ACK5, KIND_ACK6:
            begin
                if (idx >= 1)
                    fin = 1'b1;
                else if (kind_r == KIND_ACK1)
                    b = BYTE_ACK1;
                else if (kind_r == KIND_ACK5)
                    b = BYTE_ACK5;
                else
                    b = BYTE_ACK6;
                last = 1;
            end
            KIND_STEPS, KIND_POS:
            begin
                v = (kind_r == KIND_STEPS) ? int'(steps_cfg) : int'(pos_r);
                if (idx >= 2)
                    fin = 1'b1;
                else
                    b = digit_code(v, idx == 1);
                last = 2;
            end
            KIND_STICK:
            begin
                v = (idx < 2) ? int'(stick_x_cfg) : int'(stick_y_cfg);
                if (idx >= 4)
                    fin = 1'b1;
                else
                    b = digit_code(v, idx[0]);
                last = 4;
            end
            default:
            begin
                // file name: file code, then characters up to the zero or the limit
                if (idx == 0)
                    b = 8'(file_r + FILE_BIAS);
                else if (ended_r || idx > NAME_LEN)
                    fin = 1'b1;
                else
                begin
                    // a file outside the store reads as an empty name
                    if (file_r >= NUM_FILES)
                        b = '0;
                    else
                        b = names_r[file_r * NAME_LEN + idx - 1];
                    if (b == 8'd0)
                        ended_r = 1'b1;
                end
                last = NAME_LEN + 1;
            end
        endcase

        res.has = 1'b1;
        if (fin)
        begin
            busy_r       = 1'b0;
            res.tx_byte  = '0;
            res.tx_valid = 1'b0;
            res.msg_done = 1'b1;
        end
        else
        begin
            if (idx < last && !ended_r)
                idx_r = IDX_W'(idx + 1);
            res.tx_byte  = b;
            res.tx_valid = 1'b1;
            res.msg_done = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // driver: input word and output stall, changed on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (cmd_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_word <= cmd_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // monitor: both handshakes sampled on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : mon
        result_t res;
        result_t want;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            // a reply never leaves in the cycle its command arrives, so check first
            if (out_valid && out_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("unexpected reply word: byte %02h valid %0b done %0b",
                                 tx_byte, tx_valid, msg_done);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (tx_byte !== want.tx_byte || tx_valid !== want.tx_valid ||
                        msg_done !== want.msg_done)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display("reply mismatch: expected byte %02h valid %0b done %0b,",
                                     want.tx_byte, want.tx_valid, want.msg_done,
                                     " got byte %02h valid %0b done %0b",
                                     tx_byte, tx_valid, msg_done);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                res = frame_reply(cur_word);
                if (res.has)
                    reply_q.push_back(res);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cnt <= 0;
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            stall_cnt <= stall_cnt + 1;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly uniform, with the two ends of the range weighted up
    function automatic int pick(int hi);
        int r;
        r = $urandom_range(7);
        if (r == 0)
            return 0;
        if (r == 1)
            return hi;
        return $urandom_range(hi);
    endfunction

    // command word with every field random, so idle fields toggle too
    function automatic item_t rand_word(logic [1:0] op);
        item_t w;
        w.opcode       = op;
        w.message_kind = 3'($urandom_range(7));
        w.paint_byte_a = 8'(pick(255));
        w.paint_byte_b = 8'(pick(255));
        w.paint_byte_c = 8'(pick(255));
        w.paint_byte_d = 8'(pick(255));
        w.position     = VAL_W'(pick(POS_MAX));
        w.file_select  = FILE_W'($urandom_range(3));
        w.name_index   = NIDX_W'($urandom_range(15));
        w.name_char    = ($urandom_range(9) == 0) ? 8'd0 : 8'(pick(255));
        return w;
    endfunction

    task automatic queue_word(item_t w);
        cmd_q.push_back(w);
        queued_cnt++;
    endtask

    // start word, then the given number of ready words for the message,
    // with the odd name write slipped in between
    task automatic queue_message(logic [2:0] kind, logic [FILE_W-1:0] file, int readies);
        item_t w;
        w              = rand_word(OP_START);
        w.message_kind = kind;
        w.file_select  = file;
        queue_word(w);
        for (int i = 0; i < readies; i++)
        begin
            if ($urandom_range(99) < 8)
                queue_word(rand_word(OP_WRITE));
            queue_word(rand_word(OP_READY));
        end
    endtask

    function automatic int readies_for(logic [2:0] kind);
        case (kind)
            KIND_PAINT:                     return 6;
            KIND_ACK1, KIND_ACK5, KIND_ACK6: return 2;
            KIND_STEPS, KIND_POS:           return 3;
            KIND_STICK:                     return 5;
            default:                        return NAME_LEN + 2;
        endcase
    endfunction

    // register write on the falling edge, shadow follows at once
    task automatic write_reg(logic [1:0] index, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_W'(value);
        case (index)
            CFG_STEPS:   steps_cfg   = CFG_W'(value);
            CFG_STICK_X: stick_x_cfg = STICK_W'(value);
            CFG_STICK_Y: stick_y_cfg = STICK_W'(value);
            default:     ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // all words sent, all replies in, and the pipeline given time to empty
    task automatic drain();
        while (cmd_q.size() > 0 || in_valid)
            @(posedge clk);
        while (reply_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        item_t      w;
        int         target;
        int         r;
        logic [2:0] kind;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill every name entry so no message reads an unwritten one;
        // file 1 gets no zero, so its name runs to the length limit
        for (int f = 0; f < NUM_FILES; f++)
        begin
            for (int p = 0; p < NAME_LEN; p++)
            begin
                w             = rand_word(OP_WRITE);
                w.file_select = FILE_W'(f);
                w.name_index  = NIDX_W'(p);
                if (f == 1)
                    w.name_char = 8'($urandom_range(1, 255));
                else if ($urandom_range(4) == 0)
                    w.name_char = 8'd0;
                queue_word(w);
            end
        end

        // directed: ready while idle, dropped opcode, write outside the store
        queue_word(rand_word(OP_READY));
        w        = '1;
        w.opcode = OP_UNUSED;
        queue_word(w);
        w             = rand_word(OP_WRITE);
        w.file_select = FILE_W'(NUM_FILES);
        queue_word(w);
        // name that stops at the length limit
        w              = rand_word(OP_START);
        w.message_kind = KIND_NAME;
        w.file_select  = FILE_W'(1);
        queue_word(w);
        for (int i = 0; i < NAME_LEN + 2; i++)
            queue_word(rand_word(OP_READY));
        // largest position, hundreds digit wraps past a byte
        w              = rand_word(OP_START);
        w.message_kind = KIND_POS;
        w.position     = VAL_W'(POS_MAX);
        queue_word(w);
        for (int i = 0; i < 3; i++)
            queue_word(rand_word(OP_READY));
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // calibration only changes with the framer idle
            case (ph)
                0:
                begin
                    write_reg(CFG_STEPS, 0);
                    write_reg(CFG_STICK_X, 0);
                    write_reg(CFG_STICK_Y, 0);
                end
                1:
                begin
                    write_reg(CFG_STEPS, CFG_MAX);
                    write_reg(CFG_STICK_X, STICK_MAX);
                    write_reg(CFG_STICK_Y, STICK_MAX);
                end
                2:
                begin
                    write_reg(CFG_STEPS, 9999);
                    write_reg(CFG_STICK_X, 0);
                    write_reg(CFG_STICK_Y, STICK_MAX);
                end
                default:
                begin
                    write_reg(CFG_STEPS, pick(CFG_MAX));
                    // upper data bits beyond the stick width are dropped
                    write_reg(CFG_STICK_X, ($urandom_range(3) == 0) ? pick(CFG_MAX)
                                                                     : pick(STICK_MAX));
                    write_reg(CFG_STICK_Y, ($urandom_range(3) == 0) ? pick(CFG_MAX)
                                                                     : pick(STICK_MAX));
                end
            endcase
            // one stretch at full rate on both sides
            calm   = (ph == 2);
            target = queued_cnt + PHASE_WORDS;
            while (queued_cnt < target)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    kind = 3'($urandom_range(7));
                    queue_message(kind, FILE_W'($urandom_range(3)), readies_for(kind));
                end
                else if (r < 80)
                    queue_word(rand_word(OP_WRITE));
                else if (r < 86)
                    queue_word(rand_word(OP_UNUSED));
                else if (r < 92)
                    queue_word(rand_word(OP_READY));
                else
                    // cut short, the next start restarts it
                    queue_message(3'($urandom_range(7)), FILE_W'($urandom_range(3)),
                                  int'($urandom_range(3)));
            end
            drain();
        end
        calm = 1'b0;

        if (mismatch_cnt == 0 && reply_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/urmf_pkg.sv
hdl/urmf_digits.sv
hdl/urmf_name_store.sv
hdl/urmf_core.sv
hdl/uart_reply_message_framer.sv
dv/testbench.sv
